[rtl/core/ifpp_pkg.sv]
// Package for the image frame pattern pixel core.
// Holds register codes, frame mode codes, the power-of-three table and the
// structs passed between the pipeline modules. No dependencies.
package ifpp_pkg;

    // Coordinate and dimension widths fixed by the register map.
    localparam int unsigned COORD_W = 12;
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned FRAME_W = 12;

    // One carpet cell per base-3 digit that a 12-bit frame width can reach.
    localparam int unsigned NUM_CELLS = 7;

    // Reciprocal of three for a 12-bit dividend: q = (v * 2731) >> 13.
    localparam logic [11:0] RECIP3       = 12'd2731;
    localparam int unsigned RECIP3_SHIFT = 13;

    // Powers of three, entry k is 3**k.
    localparam logic [11:0] POW3 [0:NUM_CELLS] = '{
        12'd1, 12'd3, 12'd9, 12'd27, 12'd81, 12'd243, 12'd729, 12'd2187
    };

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_FRAME_WIDTH  = 3'd2,
        REG_FRAME_MODE   = 3'd3,
        REG_FILL_COLOR   = 3'd4,
        REG_HAS_ALPHA    = 3'd5
    } cfg_reg_t;

    // Frame mode codes; the fourth code writes nothing.
    localparam logic [1:0] MODE_SOLID  = 2'd0;
    localparam logic [1:0] MODE_CARPET = 2'd1;
    localparam logic [1:0] MODE_CHESS  = 2'd2;

    // Configuration as seen by the datapath, dimensions already clamped.
    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [FRAME_W-1:0] frame_width;
        logic [1:0]         frame_mode;
        logic [31:0]        fill_color;
        logic               has_alpha;
    } cfg_t;

    // Pixel item travelling down the cell chain.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               write;
        logic               colour_fixed;
        logic               is_carpet;
        logic               hit;
    } pix_t;

endpackage

[rtl/core/ifpp_cfg_regs.sv]
// Configuration register file for the image frame pattern pixel core.
// Depends on ifpp_pkg. Clamps output dimensions to MAX_DIM, capped at 8191.
module ifpp_cfg_regs
    import ifpp_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    localparam int unsigned DIM_CAP = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
    localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_CAP[DIM_W-1:0];

    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;
    logic [FRAME_W-1:0] frame_width_reg;
    logic [1:0]         frame_mode_reg;
    logic [31:0]        fill_color_reg;
    logic               has_alpha_reg;

    // Writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    // Register writes by index; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 13'd4096;
            image_height_reg <= 13'd4096;
            frame_width_reg  <= '0;
            frame_mode_reg   <= MODE_SOLID;
            fill_color_reg   <= '0;
            has_alpha_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W-1:0];
                REG_FRAME_MODE:   frame_mode_reg   <= cfg_data[1:0];
                REG_FILL_COLOR:   fill_color_reg   <= cfg_data;
                REG_HAS_ALPHA:    has_alpha_reg    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Clamp oversized dimensions.
    always_comb begin
        cfg.image_width  = (image_width_reg > DIM_CAP_V) ? DIM_CAP_V : image_width_reg;
        cfg.image_height = (image_height_reg > DIM_CAP_V) ? DIM_CAP_V : image_height_reg;
        cfg.frame_width  = frame_width_reg;
        cfg.frame_mode   = frame_mode_reg;
        cfg.fill_color   = fill_color_reg;
        cfg.has_alpha    = has_alpha_reg;
    end

endmodule

[rtl/core/ifpp_frame_stage.sv]
// First pipeline stage: decides whether a pixel lies in the frame and which
// mode applies. Depends on ifpp_pkg.
module ifpp_frame_stage
    import ifpp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] in_x,
    input  logic [COORD_W-1:0] in_y,
    output logic               out_valid,
    input  logic               out_ready,
    output pix_t               out_pix
);

    logic       valid_reg;
    pix_t       pix_reg;
    pix_t       pix_next;
    logic [DIM_W-1:0] x_ext;
    logic [DIM_W-1:0] y_ext;
    logic [DIM_W-1:0] fw_ext;
    logic [DIM_W-1:0] fw_twice;
    logic       blocked;
    logic       in_frame;

    assign x_ext    = {1'b0, in_x};
    assign y_ext    = {1'b0, in_y};
    assign fw_ext   = {1'b0, cfg.frame_width};
    assign fw_twice = {cfg.frame_width, 1'b0};

    // Cases in which nothing is written at all.
    assign blocked = (cfg.frame_width == '0) || (fw_twice > cfg.image_width)
                  || (fw_twice > cfg.image_height) || (x_ext >= cfg.image_width)
                  || (y_ext >= cfg.image_height);

    // Top, bottom, left and right bands.
    assign in_frame = (y_ext < fw_ext) || (y_ext >= cfg.image_height - fw_ext)
                   || (x_ext < fw_ext) || (x_ext >= cfg.image_width - fw_ext);

    // Mode decode for a frame pixel.
    always_comb begin
        pix_next              = '0;
        pix_next.x            = in_x;
        pix_next.y            = in_y;
        if (!blocked && in_frame) begin
            unique case (cfg.frame_mode)
                MODE_SOLID: begin
                    pix_next.write        = 1'b1;
                    pix_next.colour_fixed = 1'b1;
                end
                MODE_CHESS: begin
                    pix_next.write        = (in_x[3] == in_y[3]);
                    pix_next.colour_fixed = (in_x[3] == in_y[3]);
                end
                MODE_CARPET: begin
                    pix_next.write     = 1'b1;
                    pix_next.is_carpet = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

[rtl/core/ifpp_carpet_cell.sv]
// One carpet cell: examines one base-3 digit of x and y and passes the
// quotients to the next cell. Depends on ifpp_pkg.
module ifpp_carpet_cell
    import ifpp_pkg::*;
#(
    parameter int unsigned DIGIT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [FRAME_W-1:0] frame_width,
    input  logic               in_valid,
    output logic               in_ready,
    input  pix_t               in_pix,
    output logic               out_valid,
    input  logic               out_ready,
    output pix_t               out_pix
);

    logic       valid_reg;
    pix_t       pix_reg;
    pix_t       pix_next;
    logic [2*COORD_W-1:0] prod_x;
    logic [2*COORD_W-1:0] prod_y;
    logic [COORD_W-1:0]   quot_x;
    logic [COORD_W-1:0]   quot_y;
    logic [COORD_W-1:0]   rem_x;
    logic [COORD_W-1:0]   rem_y;
    logic                 active;

    // Divide by three through the reciprocal; exact for 12-bit values.
    assign prod_x = in_pix.x * RECIP3;
    assign prod_y = in_pix.y * RECIP3;
    assign quot_x = COORD_W'(prod_x >> RECIP3_SHIFT);
    assign quot_y = COORD_W'(prod_y >> RECIP3_SHIFT);
    assign rem_x  = in_pix.x - {quot_x[COORD_W-2:0], 1'b0} - quot_x;
    assign rem_y  = in_pix.y - {quot_y[COORD_W-2:0], 1'b0} - quot_y;

    // This digit counts only while the period fits in the frame width.
    assign active = (frame_width >= POW3[DIGIT+1]);

    always_comb begin
        pix_next     = in_pix;
        pix_next.x   = quot_x;
        pix_next.y   = quot_y;
        pix_next.hit = in_pix.hit
                     | (active && (rem_x == COORD_W'(1)) && (rem_y == COORD_W'(1)));
    end

    assign in_ready = !valid_reg || out_ready;

    // Cell register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

[rtl/core/image_frame_pattern_pixel_core.sv]
// Image frame pattern pixel core: solid, checkerboard or carpet border frame.
// The pipeline is one frame stage, one cell per base-3 digit (7 cells),
// and the output register.
// Throughput is one item per cycle; each stage stalls only when it is full
// and the stage after it cannot take its item.
// Synchronous active-low reset empties the pipeline and loads register defaults.
module image_frame_pattern_pixel_core
    import ifpp_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_pixel_x,
    input  logic [11:0] s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_pixel,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha
);

    cfg_t cfg;
    logic chain_valid [0:NUM_CELLS];
    logic chain_ready [0:NUM_CELLS];
    pix_t chain_pix   [0:NUM_CELLS];

    logic       out_valid_reg;
    logic       out_write_reg;
    logic [7:0] out_red_reg;
    logic [7:0] out_green_reg;
    logic [7:0] out_blue_reg;
    logic [7:0] out_alpha_reg;
    logic       out_in_ready;
    logic       colour;

    // Configuration registers.
    ifpp_cfg_regs #(
        .MAX_DIM(MAX_DIM)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame membership and mode decode.
    ifpp_frame_stage u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_x      (s_pixel_x),
        .in_y      (s_pixel_y),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_pix   (chain_pix[0])
    );

    // Row of carpet cells, one base-3 digit each.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        ifpp_carpet_cell #(
            .DIGIT(i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .frame_width (cfg.frame_width),
            .in_valid    (chain_valid[i]),
            .in_ready    (chain_ready[i]),
            .in_pix      (chain_pix[i]),
            .out_valid   (chain_valid[i+1]),
            .out_ready   (chain_ready[i+1]),
            .out_pix     (chain_pix[i+1])
        );
    end

    // Output register with the colour applied.
    assign out_in_ready          = !out_valid_reg || m_ready;
    assign chain_ready[NUM_CELLS] = out_in_ready;
    assign colour = chain_pix[NUM_CELLS].is_carpet ? chain_pix[NUM_CELLS].hit
                                                   : chain_pix[NUM_CELLS].colour_fixed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_in_ready) begin
            out_valid_reg <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_in_ready && chain_valid[NUM_CELLS]) begin
            out_write_reg <= chain_pix[NUM_CELLS].write;
            if (chain_pix[NUM_CELLS].write && colour) begin
                out_red_reg   <= cfg.fill_color[31:24];
                out_green_reg <= cfg.fill_color[23:16];
                out_blue_reg  <= cfg.fill_color[15:8];
                out_alpha_reg <= cfg.has_alpha ? cfg.fill_color[7:0] : 8'd0;
            end else begin
                out_red_reg   <= 8'd0;
                out_green_reg <= 8'd0;
                out_blue_reg  <= 8'd0;
                out_alpha_reg <= 8'd0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_write_pixel = out_write_reg;
    assign m_red         = out_red_reg;
    assign m_green       = out_green_reg;
    assign m_blue        = out_blue_reg;
    assign m_alpha       = out_alpha_reg;

endmodule

[rtl/core/ifpp_checker.sv]
// Port-level checker for the image frame pattern pixel core, with its bind.
// Sees only the top-level ports; no package dependency.
module ifpp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_write_pixel,
    input logic [7:0] m_red,
    input logic [7:0] m_green,
    input logic [7:0] m_blue,
    input logic [7:0] m_alpha
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_pixel) && $stable(m_red)
            && $stable(m_green) && $stable(m_blue) && $stable(m_alpha))
        else $error("result changed while stalled");

    // A pixel that is not written carries no colour.
    a_zero_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_pixel |-> m_red == 8'd0 && m_green == 8'd0
            && m_blue == 8'd0 && m_alpha == 8'd0)
        else $error("colour on an unwritten pixel");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result present after reset");

    // With the consumer ready, no stage can be blocked.
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

endmodule

bind image_frame_pattern_pixel_core ifpp_checker u_ifpp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_write_pixel (m_write_pixel),
    .m_red         (m_red),
    .m_green       (m_green),
    .m_blue        (m_blue),
    .m_alpha       (m_alpha)
);
